@@ hw/rtl/amcd_pkg.sv @@
// Shared types and constants of the AVI movie chunk demultiplexer.
package amcd_pkg;

	localparam int AMCD_QUEUE_DEPTH = 4;
	localparam int AMCD_CFG_INDEX_W = 8;
	localparam int AMCD_CFG_DATA_W  = 32;

	// Configuration register indexes.
	localparam logic [AMCD_CFG_INDEX_W-1:0] CFG_STREAM_COUNT = 8'd0;
	localparam logic [AMCD_CFG_INDEX_W-1:0] CFG_MOVIE_LENGTH = 8'd1;

	typedef enum logic [1:0] {
		KIND_PAYLOAD    = 2'd0,
		KIND_EMPTY      = 2'd1,
		KIND_BAD_STREAM = 2'd2,
		KIND_END        = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] stream;
		logic [7:0] payload;
		logic       last;
	} res_t;

	// Up to two results per accepted byte; wr1 is only used together with wr0.
	typedef struct packed {
		logic wr0;
		logic wr1;
		res_t res0;
		res_t res1;
	} qwr_t;

endpackage

@@ hw/rtl/amcd_front.sv @@
// Front end: byte parser that classifies chunks and emits result beats.
module amcd_front import amcd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        room,
	input  logic [7:0]                  data_byte,
	input  logic                        cfg_valid,
	input  logic [AMCD_CFG_INDEX_W-1:0] cfg_index,
	input  logic [AMCD_CFG_DATA_W-1:0]  cfg_data,
	output qwr_t                        qwr
);

	typedef enum logic [5:0] {
		PH_HEADER   = 6'b000001,
		PH_SKIP     = 6'b000010,
		PH_DATA     = 6'b000100,
		PH_LISTTYPE = 6'b001000,
		PH_HALT     = 6'b010000,
		PH_END      = 6'b100000
	} phase_t;

	localparam logic [31:0] FCC_JUNK = 32'h4B4E554A;
	localparam logic [31:0] FCC_IDX1 = 32'h31786469;
	localparam logic [31:0] FCC_LIST = 32'h5453494C;
	localparam logic [31:0] FCC_REC  = 32'h20636572;

	// Bit 4 flags a character that is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'b10000;
		if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
		return v;
	endfunction

	phase_t      phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [31:0] fcc_q, fcc_n;
	logic [31:0] size_q, size_n;
	logic [32:0] rem_q, rem_n;
	logic [7:0]  stream_q, stream_n;
	logic [31:0] pos_q, pos_n;
	logic        pad_q, pad_n;
	logic [7:0]  stream_count_q;
	logic [31:0] movie_length_q;

	logic        accept;
	logic        own_v, eom_v;
	res_t        own_res, eom_res;
	logic [32:0] rounded;
	logic [4:0]  hi, lo;
	logic [7:0]  sid;

	assign accept = push && room;

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		fcc_n    = fcc_q;
		size_n   = size_q;
		rem_n    = rem_q;
		stream_n = stream_q;
		pos_n    = pos_q;
		pad_n    = pad_q;
		own_v    = 1'b0;
		own_res  = '{kind: KIND_PAYLOAD, stream: stream_q, payload: data_byte, last: 1'b0};
		eom_v    = 1'b0;
		eom_res  = '{kind: KIND_END, stream: 8'd0, payload: 8'd0, last: 1'b0};
		rounded  = '0;
		hi       = '0;
		lo       = '0;
		sid      = '0;
		if (phase_q != PH_HALT && phase_q != PH_END) begin
			if (pos_q != 32'hFFFF_FFFF) pos_n = pos_q + 32'd1;
			unique case (phase_q)
				PH_HEADER: begin
					if (!idx_q[2]) fcc_n[{idx_q[1:0], 3'b000} +: 8] = data_byte;
					else size_n[{idx_q[1:0], 3'b000} +: 8] = data_byte;
					idx_n = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						rounded = {1'b0, size_n} + {32'd0, size_n[0]};
						hi  = hex_value(fcc_n[7:0]);
						lo  = hex_value(fcc_n[15:8]);
						sid = (hi[4] || lo[4]) ? 8'hFF : {hi[3:0], lo[3:0]};
						if (fcc_n == FCC_JUNK || fcc_n == FCC_IDX1) begin
							rem_n   = rounded;
							phase_n = (rounded == '0) ? PH_HEADER : PH_SKIP;
						end else if (fcc_n == FCC_LIST) begin
							phase_n = PH_LISTTYPE;
						end else begin
							stream_n = sid;
							if (sid >= stream_count_q) begin
								own_v   = 1'b1;
								own_res = '{kind: KIND_BAD_STREAM, stream: sid,
								            payload: 8'd0, last: 1'b0};
								phase_n = PH_HALT;
							end else if (size_n == '0) begin
								own_v   = 1'b1;
								own_res = '{kind: KIND_EMPTY, stream: sid,
								            payload: 8'd0, last: 1'b0};
								phase_n = PH_HEADER;
							end else begin
								rem_n   = {1'b0, size_n};
								pad_n   = size_n[0];
								phase_n = PH_DATA;
							end
						end
					end
				end
				PH_LISTTYPE: begin
					fcc_n[{idx_q[1:0], 3'b000} +: 8] = data_byte;
					idx_n = {1'b0, idx_q[1:0] + 2'd1};
					if (idx_q[1:0] == 2'd3) begin
						if (fcc_n == FCC_REC) begin
							phase_n = PH_HEADER;
						end else begin
							rounded = {1'b0, size_q} + {32'd0, size_q[0]};
							rem_n   = (rounded >= 33'd4) ? rounded - 33'd4 : '0;
							phase_n = (rem_n == '0) ? PH_HEADER : PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					if (rem_q != '0) rem_n = rem_q - 33'd1;
					if (rem_n == '0) phase_n = PH_HEADER;
				end
				PH_DATA: begin
					if (rem_q != '0) rem_n = rem_q - 33'd1;
					own_v = 1'b1;
					if (rem_n == '0) begin
						own_res.last = 1'b1;
						if (pad_q) begin
							// Drop the pad byte of an odd-sized chunk.
							pad_n   = 1'b0;
							rem_n   = 33'd1;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_HEADER;
						end
					end
				end
				default: begin
					phase_n = PH_HEADER;
					idx_n   = '0;
				end
			endcase
			if (pos_n >= movie_length_q) begin
				eom_v = 1'b1;
				if (phase_n != PH_HALT) phase_n = PH_END;
			end
		end
	end

	always_comb begin
		qwr.wr0  = accept && (own_v || eom_v);
		qwr.wr1  = accept && own_v && eom_v;
		qwr.res0 = own_v ? own_res : eom_res;
		qwr.res1 = eom_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			idx_q    <= '0;
			fcc_q    <= '0;
			size_q   <= '0;
			rem_q    <= '0;
			stream_q <= '0;
			pos_q    <= '0;
			pad_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			fcc_q    <= fcc_n;
			size_q   <= size_n;
			rem_q    <= rem_n;
			stream_q <= stream_n;
			pos_q    <= pos_n;
			pad_q    <= pad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_count_q <= 8'd1;
			movie_length_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_STREAM_COUNT) stream_count_q <= cfg_data[7:0];
			else if (cfg_index == CFG_MOVIE_LENGTH) movie_length_q <= cfg_data[31:0];
		end
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT || phase_q == PH_END) |-> !qwr.wr0)
		else $error("result emitted after halt or end of movie");

	a_pair_is_eom: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.wr1 |-> (qwr.wr0 && qwr.res1.kind == KIND_END))
		else $error("second result is not end of movie");

	a_end_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_END) |=> (phase_q == PH_END))
		else $error("parser left end of movie");

endmodule

@@ hw/rtl/amcd_queue.sv @@
// Short result queue between the parser and the output stage.
module amcd_queue import amcd_pkg::*; #(
	parameter int DEPTH = AMCD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  qwr_t qwr,
	input  logic rd,
	output res_t head,
	output logic q_empty,
	output logic room
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PW'(1);
	endfunction

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [CW-1:0] count_q;

	assign wr_ptr1 = inc(wr_ptr_q);
	assign head    = mem_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	// Leave space for the two beats a single byte may produce.
	assign room    = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (qwr.wr0) mem_q[wr_ptr_q] <= qwr.res0;
		if (qwr.wr1) mem_q[wr_ptr1]  <= qwr.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.wr1) wr_ptr_q <= inc(wr_ptr1);
			else if (qwr.wr0) wr_ptr_q <= wr_ptr1;
			if (rd) rd_ptr_q <= inc(rd_ptr_q);
			count_q <= count_q + CW'(qwr.wr0) + CW'(qwr.wr1) - CW'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !q_empty)
		else $error("read from empty result queue");

	a_write_order: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.wr1 |-> (qwr.wr0 && room))
		else $error("second write without first or without space");

endmodule

@@ hw/rtl/amcd_back.sv @@
// Back end: output register that presents the oldest result beat.
module amcd_back import amcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  res_t head,
	input  logic q_empty,
	input  logic pop,
	output logic rd,
	output logic empty,
	output res_t out_res
);

	logic out_valid_q;
	res_t out_q;

	assign empty   = !out_valid_q;
	assign out_res = out_q;
	// Refill when the register is free or its beat is taken this cycle.
	assign rd      = !q_empty && (!out_valid_q || pop);

	always_ff @(posedge clk) begin
		if (rd) out_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (rd) out_valid_q <= 1'b1;
		else if (pop) out_valid_q <= 1'b0;
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result changed");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |-> !rd)
		else $error("output overwritten before pop");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && !out_valid_q) |-> rd)
		else $error("output register idle while results wait");

endmodule

@@ hw/rtl/avi_movie_chunk_demux.sv @@
// Top level of the AVI movie chunk demultiplexer.
//
// Input channel: one raw byte of movie list content per beat on data_byte,
// taken at a clock edge with push high and full low.
// Result channel: queue-like; while empty is low the oldest result sits on
// result_kind, stream_id, payload_byte and chunk_last, and it is taken at
// an edge with pop high. Kinds: payload byte, empty chunk, bad stream, end
// of movie. A byte yields at most two beats (its own, then end of movie).
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0
// is stream_count, index 1 is movie_length, other indexes are ignored.
// Throughput: one byte per cycle while full is low; the parser updates its
// counters for a byte at the edge that takes it, and the queue takes both
// beats of a byte at once. The queue takes a result at the edge that accepts
// its byte, and the output register takes it from the queue once the
// register is free or its beat is being popped.
// Stall: when pop stays low the output register holds its beat, the queue
// fills, and full rises once fewer than two queue slots are left.
// Reset: arst_n clears the parser to header state, the queue and the output
// register; stream_count returns to 1 and movie_length to 0. After a bad
// stream or end of movie, bytes are still taken but dropped until reset.
module avi_movie_chunk_demux import amcd_pkg::*; #(
	parameter int QUEUE_DEPTH = AMCD_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  data_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  result_kind,
	output logic [7:0]                  stream_id,
	output logic [7:0]                  payload_byte,
	output logic                        chunk_last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [AMCD_CFG_INDEX_W-1:0] cfg_index,
	input  logic [AMCD_CFG_DATA_W-1:0]  cfg_data
);

	qwr_t qwr;
	res_t head, out_res;
	logic room, q_empty, rd;

	// Registers accept a beat in every cycle.
	assign cfg_ready = 1'b1;
	assign full      = !room;

	amcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.data_byte (data_byte),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qwr       (qwr)
	);

	amcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.qwr     (qwr),
		.rd      (rd),
		.head    (head),
		.q_empty (q_empty),
		.room    (room)
	);

	amcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.rd      (rd),
		.empty   (empty),
		.out_res (out_res)
	);

	assign result_kind  = out_res.kind;
	assign stream_id    = out_res.stream;
	assign payload_byte = out_res.payload;
	assign chunk_last   = out_res.last;

endmodule
